FILE: rtl/clock_frame_replacement_macros.svh
// ----------------------------------------------------------------------------
// clock frame replacement assertion macros
// shared concurrent assertion forms, clocked on i_clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef CLOCK_FRAME_REPLACEMENT_MACROS_SVH
`define CLOCK_FRAME_REPLACEMENT_MACROS_SVH

// condition holds at every edge
`define CFR_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// types and constants of the clock frame replacement block
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int FRAME_W    = 6;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_TOUCH = 2'd2,
        MODE_PIN   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FRAME   = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } t_status;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_ZERO = 2'd0;
    localparam t_kind KIND_FILE = 2'd1;
    localparam t_kind KIND_SWAP = 2'd2;

    // one row of frame state as kept in the frame table
    typedef struct packed {
        logic  in_use;
        logic  pinned;
        logic  referenced;
        logic  dirty;
        t_kind kind;
    } t_frame_row;

    localparam int ROW_W = $bits(t_frame_row);

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic               evicted;
        logic               writeback;
        t_kind              vkind;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_ACCESS,
        S_OUT
    } t_state;

    // fresh page: in use, unpinned, unreferenced, clean
    function automatic t_frame_row claim_row(input t_kind kind);
        t_frame_row row;
        row            = '0;
        row.in_use     = 1'b1;
        row.kind       = kind;
        return row;
    endfunction

endpackage

FILE: rtl/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/clock_frame_replacement.sv
// ----------------------------------------------------------------------------
// clock_frame_replacement
// physical frame manager with second-chance clock eviction
// ----------------------------------------------------------------------------
// Each request on the slave stream is one of allocate, free, touch or pin and
// gives exactly one result on the master stream. Frame state lives in a
// NUM_FRAMES-deep table ram, one row per frame, and a small sequencer walks it
// one row per cycle through a single compare/update path. After reset the
// table is cleared row by row, during which no request is taken. A free,
// touch or pin reads the row of its frame and updates it, or goes straight
// to its result when the frame index lies past the table; an allocate with
// a free frame scans up from frame zero to the lowest free frame; an
// allocate on a full table sweeps from the clock hand, which visits 1 up to
// 2*NUM_FRAMES slots (all of them when every frame is pinned). The walk over
// the table ram, one read per cycle, sets how long each request takes.
// The next request is taken as soon as the result
// sits in the output register, even while that result waits to be taken; a
// result that cannot be loaded holds the sequencer until the register drains.
// ----------------------------------------------------------------------------
`include "clock_frame_replacement_macros.svh"

module clock_frame_replacement #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] frame_index, [7:6] page_kind, [8] write_access, [9] pin_value
    input  logic [cfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  logic [cfr_pkg::MODE_W-1:0]       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] result_frame, [7:6] status, [8] evicted, [9] needs_writeback,
    // [11:10] victim_kind
    output logic [cfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import cfr_pkg::*;

    // frame address width, count width (holds NUM_FRAMES itself)
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = FW + 1;
    // index compare width, wide enough for both the field and NUM_FRAMES
    localparam int IW = ((FW > FRAME_W) ? FW : FRAME_W) + 1;

    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL_CNT   = CW'(NUM_FRAMES);
    // two full sweeps of the hand, counted from zero
    localparam logic [FW:0]   LAST_STEP  = (FW + 1)'(2 * NUM_FRAMES - 1);
    localparam logic [IW-1:0] IDX_LIMIT  = IW'(NUM_FRAMES);

    // sequencer state
    t_state        r_state, n_state;
    logic [FW-1:0] r_ptr, n_ptr;          // frame whose row arrives this cycle
    logic [FW-1:0] r_hand, n_hand;        // clock hand
    logic [FW:0]   r_steps, n_steps;      // slots visited in this sweep
    logic [CW-1:0] r_used_cnt, n_used_cnt;
    logic          r_out_valid, n_out_valid;

    // latched request
    t_mode              r_mode, n_mode;
    t_kind              r_kind, n_kind;
    logic               r_wr, n_wr;
    logic               r_pin, n_pin;

    // result being built and result register
    t_result r_res, n_res;
    t_result r_out, n_out;

    // table ram port signals
    logic          w_wr_en;
    logic [FW-1:0] w_wr_addr;
    t_frame_row    w_wr_row;
    logic [FW-1:0] w_rd_addr;
    logic [ROW_W-1:0] w_rd_data;
    t_frame_row    w_row;

    // request fields off the slave stream
    t_mode              w_in_mode;
    logic [FRAME_W-1:0] w_in_frame;
    t_kind              w_in_kind;
    logic               w_in_wr;
    logic               w_in_pin;
    logic               w_accept;
    logic               w_in_range;
    logic               w_full;
    logic [FW-1:0]      w_next_ptr;
    logic               w_victim;
    logic               w_out_free;

    assign w_in_mode  = t_mode'(s_axis_tuser);
    assign w_in_frame = s_axis_tdata[FRAME_W-1:0];
    assign w_in_kind  = s_axis_tdata[FRAME_W +: KIND_W];
    assign w_in_wr    = s_axis_tdata[FRAME_W + KIND_W];
    assign w_in_pin   = s_axis_tdata[FRAME_W + KIND_W + 1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_in_range = IW'(w_in_frame) < IDX_LIMIT;
    assign w_full     = (r_used_cnt == FULL_CNT);
    assign w_next_ptr = (r_ptr == LAST_FRAME) ? '0 : r_ptr + FW'(1);
    assign w_row      = t_frame_row'(w_rd_data);
    // in use, unpinned and with its second chance used up
    assign w_victim   = w_row.in_use && !w_row.pinned && !w_row.referenced;
    assign w_out_free = !r_out_valid || m_axis_tready;

    cfr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_FRAMES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_row),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_ptr == LAST_FRAME) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_mode == MODE_ALLOC) begin
                        n_state = w_full ? S_SWEEP : S_SCAN;
                    end else begin
                        n_state = w_in_range ? S_ACCESS : S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (!w_row.in_use) n_state = S_OUT;
            end
            S_SWEEP: begin
                if (w_victim || r_steps == LAST_STEP) n_state = S_OUT;
            end
            S_ACCESS: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and table accesses
    always_comb begin
        n_ptr      = r_ptr;
        n_hand     = r_hand;
        n_steps    = r_steps;
        n_used_cnt = r_used_cnt;
        n_mode     = r_mode;
        n_kind     = r_kind;
        n_wr       = r_wr;
        n_pin      = r_pin;
        n_res      = r_res;
        n_out      = r_out;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_ptr;
        w_wr_row   = w_row;
        w_rd_addr  = w_next_ptr;

        // result register drains independent of the sequencer
        n_out_valid = r_out_valid && !m_axis_tready;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en  = 1'b1;
                w_wr_row = '0;
                n_ptr    = w_next_ptr;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_mode    = w_in_mode;
                    n_kind    = w_in_kind;
                    n_wr      = w_in_wr;
                    n_pin     = w_in_pin;
                    n_steps   = '0;
                    n_res     = '{frame: w_in_frame, status: ST_OK, evicted: 1'b0,
                                  writeback: 1'b0, vkind: KIND_ZERO};
                    if (w_in_mode == MODE_ALLOC) begin
                        // scan starts at frame zero, eviction at the hand
                        w_rd_addr = w_full ? r_hand : '0;
                        n_res.frame = '0;
                    end else begin
                        w_rd_addr = FW'(w_in_frame);
                        if (!w_in_range) n_res.status = ST_NOT_IN_USE;
                    end
                    n_ptr = w_rd_addr;
                end
            end
            S_SCAN: begin
                if (!w_row.in_use) begin
                    w_wr_en     = 1'b1;
                    w_wr_row    = claim_row(r_kind);
                    n_res.frame = FRAME_W'(r_ptr);
                    n_used_cnt  = r_used_cnt + CW'(1);
                end else begin
                    n_ptr = w_next_ptr;
                end
            end
            S_SWEEP: begin
                if (w_victim) begin
                    w_wr_en         = 1'b1;
                    w_wr_row        = claim_row(r_kind);
                    n_res.frame     = FRAME_W'(r_ptr);
                    n_res.evicted   = 1'b1;
                    n_res.writeback = w_row.dirty || (w_row.kind == KIND_ZERO);
                    n_res.vkind     = (w_row.kind == KIND_FILE && !w_row.dirty) ?
                                      KIND_FILE : KIND_SWAP;
                    n_hand          = w_next_ptr;
                end else begin
                    // referenced and unpinned: use up its second chance
                    if (w_row.in_use && !w_row.pinned) begin
                        w_wr_en             = 1'b1;
                        w_wr_row.referenced = 1'b0;
                    end
                    n_ptr   = w_next_ptr;
                    n_steps = r_steps + (FW + 1)'(1);
                    if (r_steps == LAST_STEP) begin
                        // every frame pinned, hand back where it started
                        n_res.status = ST_NO_FRAME;
                        n_res.frame  = '0;
                        n_hand       = w_next_ptr;
                    end
                end
            end
            S_ACCESS: begin
                if (!w_row.in_use) begin
                    n_res.status = ST_NOT_IN_USE;
                end else begin
                    w_wr_en = 1'b1;
                    case (r_mode)
                        MODE_FREE: begin
                            w_wr_row   = '0;
                            n_used_cnt = r_used_cnt - CW'(1);
                        end
                        MODE_TOUCH: begin
                            w_wr_row.referenced = 1'b1;
                            w_wr_row.dirty      = w_row.dirty || r_wr;
                        end
                        MODE_PIN: begin
                            w_wr_row.pinned = r_pin;
                        end
                        default: begin
                            w_wr_en = 1'b0;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_hand      <= '0;
            r_steps     <= '0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_hand      <= n_hand;
            r_steps     <= n_steps;
            r_used_cnt  <= n_used_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_kind  <= n_kind;
        r_wr    <= n_wr;
        r_pin   <= n_pin;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - FRAME_W - STATUS_W - 2 - KIND_W)'(0),
                            r_out.vkind, r_out.writeback, r_out.evicted,
                            r_out.status, r_out.frame};

    // frame count never runs past the table
    `CFR_ASSERT_HOLD(a_cnt_bound, r_used_cnt <= FULL_CNT, "frame count above table size")
    // the hand only sweeps a full table
    `CFR_ASSERT_IMPL(a_sweep_full, r_state == S_SWEEP,
        r_used_cnt == FULL_CNT, "sweep with free frame")
    // sweep ends after two passes at most
    `CFR_ASSERT_IMPL(a_sweep_len, r_state == S_SWEEP, r_steps <= LAST_STEP, "sweep too long")
    // a fresh allocation claims exactly one frame
    `CFR_ASSERT_NEXT(a_scan_claim, r_state == S_SCAN && !w_row.in_use,
        r_used_cnt == $past(r_used_cnt) + CW'(1), "fresh claim not counted")
    // the hand stays put during a fresh allocation
    `CFR_ASSERT_NEXT(a_scan_hand, r_state == S_SCAN, $stable(r_hand), "hand moved in scan")

endmodule
